// ===== src/slp_pkg.sv =====
package slp_pkg;

    localparam int PAGE_BYTES_DEF = 128;
    localparam int HDR_LEN        = 6;

    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_END   = 8'hF7;
    localparam logic [6:0] CMD_RESET = 7'h7F;
    localparam logic [6:0] CMD_PAGE  = 7'h7E;
    localparam logic [6:0] CMD_ARG   = 7'h00;

    localparam logic [1:0] EV_PAGE  = 2'd0;
    localparam logic [1:0] EV_RESET = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    typedef struct packed {
        logic hdr_step;
        logic cmd_store;
        logic data_nib;
        logic to_hdr;
        logic end_msg;
        logic rd;
        logic load_evt;
        logic load_word;
    } t_cmd;

    typedef struct packed {
        logic rt;
        logic st;
        logic eox;
        logic hdr_done;
        logic cmd_last;
        logic page_ok;
        logic out_free;
        logic last_word;
    } t_sts;

    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = SYX_START;
            3'd1:    v = 8'h00;
            3'd2:    v = 8'h20;
            3'd3:    v = 8'h77;
            3'd4:    v = 8'h00;
            3'd5:    v = 8'h03;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== src/sysex_page_loader_parser.sv =====
// channel  dir  handshake           beat payload
// input    in   i_valid / o_ready   i_rx_byte
// output   out  o_valid / i_ready   o_event_kind, o_page_address, o_word_offset,
//                                   o_data_word, o_last
//
// Parsed bytes can be taken back to back while o_ready is high.
// An end byte giving a reset or error event holds input until the event is loaded.
// A page end walks two banked page RAMs: a read and a load step per word,
// (PAGE_BYTES+1)/2 words, plus output stalls; input is held until the last word is loaded.
// Output is registered, so bytes keep being taken while a result waits.
// Reset: synchronous, active low; no clearing pass.
module sysex_page_loader_parser #(
    parameter int PAGE_BYTES = slp_pkg::PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_kind,
    output logic [15:0] o_page_address,
    output logic [5:0]  o_word_offset,
    output logic [15:0] o_data_word,
    output logic        o_last
);

    import slp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    slp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    slp_dp #(.PAGE_BYTES(PAGE_BYTES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_event_kind   (o_event_kind),
        .o_page_address (o_page_address),
        .o_word_offset  (o_word_offset),
        .o_data_word    (o_data_word),
        .o_last         (o_last)
    );

endmodule

// ===== src/slp_ram.sv =====
module slp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/slp_dp.sv =====
module slp_dp #(
    parameter int PAGE_BYTES = slp_pkg::PAGE_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_rx_byte,
    input  slp_pkg::t_cmd i_cmd,
    output slp_pkg::t_sts o_sts,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [1:0]    o_event_kind,
    output logic [15:0]   o_page_address,
    output logic [5:0]    o_word_offset,
    output logic [15:0]   o_data_word,
    output logic          o_last
);

    import slp_pkg::*;

    localparam int FILL_W     = $clog2(PAGE_BYTES + 3);
    localparam int BANK_DEPTH = PAGE_BYTES / 2 + 1;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int WORDS      = (PAGE_BYTES + 1) / 2;

    logic [8:0]         r_cnt, n_cnt;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_ck, n_ck;
    logic [3:0]         r_hi, n_hi;
    logic [6:0]         r_cmd0, n_cmd0;
    logic [6:0]         r_cmd1, n_cmd1;
    logic [15:0]        r_next_page, n_next_page;
    logic [BANK_AW-1:0] r_word, n_word;
    logic [1:0]         r_kind, n_kind;

    logic               r_ovalid, n_ovalid;
    logic [1:0]         r_okind, n_okind;
    logic [15:0]        r_oaddr, n_oaddr;
    logic [5:0]         r_ooff, n_ooff;
    logic [15:0]        r_odata, n_odata;
    logic               r_olast, n_olast;

    logic               hdr_match;
    logic               is_reset_msg;
    logic               in_page;
    logic [7:0]         full_byte;
    logic               we_even, we_odd;
    logic [BANK_AW-1:0] waddr;
    logic [7:0]         rd_even, rd_odd;
    logic               out_free;

    assign hdr_match    = (i_rx_byte == hdr_byte(r_cnt[2:0]));
    assign is_reset_msg = (r_cmd0 == CMD_RESET) && (r_cmd1 == CMD_ARG) && (r_cnt == 9'd0);
    assign in_page      = (r_fill < FILL_W'(PAGE_BYTES + 1));
    assign full_byte    = {r_hi, i_rx_byte[3:0]};
    assign waddr        = BANK_AW'(r_fill >> 1);
    assign we_even      = i_cmd.data_nib && r_cnt[0] && in_page && !r_fill[0];
    assign we_odd       = i_cmd.data_nib && r_cnt[0] && in_page && r_fill[0];
    assign out_free     = !r_ovalid || i_ready;

    always_comb begin
        o_sts.rt        = (i_rx_byte > SYX_START) && (i_rx_byte != SYX_END);
        o_sts.st        = i_rx_byte[7];
        o_sts.eox       = (i_rx_byte == SYX_END);
        o_sts.hdr_done  = hdr_match && (r_cnt == 9'(HDR_LEN - 1));
        o_sts.cmd_last  = r_cnt[0];
        o_sts.page_ok   = !is_reset_msg && (r_fill == FILL_W'(PAGE_BYTES + 1))
                          && (r_cmd0 == CMD_PAGE) && (r_cmd1 == CMD_ARG) && (r_ck == r_sum);
        o_sts.out_free  = out_free;
        o_sts.last_word = (r_word == BANK_AW'(WORDS - 1));
    end

    slp_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even (
        .i_clk   (i_clk),
        .i_we    (we_even),
        .i_waddr (waddr),
        .i_wdata (full_byte),
        .i_re    (i_cmd.rd),
        .i_raddr (r_word),
        .o_rdata (rd_even)
    );

    slp_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd (
        .i_clk   (i_clk),
        .i_we    (we_odd),
        .i_waddr (waddr),
        .i_wdata (full_byte),
        .i_re    (i_cmd.rd),
        .i_raddr (r_word),
        .o_rdata (rd_odd)
    );

    always_comb begin
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_ck        = r_ck;
        n_hi        = r_hi;
        n_cmd0      = r_cmd0;
        n_cmd1      = r_cmd1;
        n_next_page = r_next_page;
        n_word      = r_word;
        n_kind      = r_kind;
        n_ovalid    = r_ovalid && !i_ready;
        n_okind     = r_okind;
        n_oaddr     = r_oaddr;
        n_ooff      = r_ooff;
        n_odata     = r_odata;
        n_olast     = r_olast;

        if (i_cmd.hdr_step) begin
            if (hdr_match && (r_cnt != 9'(HDR_LEN - 1))) begin
                n_cnt = r_cnt + 9'd1;
            end else begin
                n_cnt = 9'd0;
            end
        end

        if (i_cmd.cmd_store) begin
            if (r_cnt[0]) begin
                n_cmd1 = i_rx_byte[6:0];
                n_cnt  = 9'd0;
                n_fill = '0;
                n_sum  = 8'd0;
            end else begin
                n_cmd0 = i_rx_byte[6:0];
                n_cnt  = r_cnt + 9'd1;
            end
        end

        if (i_cmd.data_nib) begin
            if (r_cnt[0]) begin
                if (r_fill < FILL_W'(PAGE_BYTES)) begin
                    n_sum = r_sum + full_byte;
                end
                if (r_fill == FILL_W'(PAGE_BYTES)) begin
                    n_ck = full_byte;
                end
                if (r_fill < FILL_W'(PAGE_BYTES + 2)) begin
                    n_fill = r_fill + FILL_W'(1);
                end
            end else if (in_page) begin
                n_hi = i_rx_byte[3:0];
            end
            n_cnt = (r_cnt == 9'd511) ? 9'd510 : r_cnt + 9'd1;
        end

        if (i_cmd.to_hdr) begin
            n_cnt = 9'd0;
        end

        if (i_cmd.end_msg) begin
            n_kind = is_reset_msg ? EV_RESET : EV_ERROR;
            n_word = '0;
            n_cnt  = 9'd0;
        end

        if (i_cmd.load_evt) begin
            n_ovalid = 1'b1;
            n_okind  = r_kind;
            n_oaddr  = r_next_page;
            n_ooff   = 6'd0;
            n_odata  = 16'd0;
            n_olast  = 1'b1;
        end

        if (i_cmd.load_word) begin
            n_ovalid = 1'b1;
            n_okind  = EV_PAGE;
            n_oaddr  = r_next_page;
            n_ooff   = 6'(r_word);
            n_odata  = {rd_odd, rd_even};
            n_olast  = o_sts.last_word;
            if (o_sts.last_word) begin
                n_next_page = r_next_page + 16'(PAGE_BYTES);
            end else begin
                n_word = r_word + BANK_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 9'd0;
            r_fill      <= '0;
            r_sum       <= 8'd0;
            r_cmd0      <= 7'd0;
            r_cmd1      <= 7'd0;
            r_next_page <= 16'd0;
            r_word      <= '0;
            r_kind      <= EV_ERROR;
            r_ovalid    <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_cmd0      <= n_cmd0;
            r_cmd1      <= n_cmd1;
            r_next_page <= n_next_page;
            r_word      <= n_word;
            r_kind      <= n_kind;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ck    <= n_ck;
        r_hi    <= n_hi;
        r_okind <= n_okind;
        r_oaddr <= n_oaddr;
        r_ooff  <= n_ooff;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign o_valid        = r_ovalid;
    assign o_event_kind   = r_okind;
    assign o_page_address = r_oaddr;
    assign o_word_offset  = r_ooff;
    assign o_data_word    = r_odata;
    assign o_last         = r_olast;

endmodule

// ===== src/slp_ctrl.sv =====
module slp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  slp_pkg::t_sts i_sts,
    output slp_pkg::t_cmd o_cmd
);

    import slp_pkg::*;

    localparam logic [2:0] S_HDR  = 3'd0;
    localparam logic [2:0] S_CMD  = 3'd1;
    localparam logic [2:0] S_DATA = 3'd2;
    localparam logic [2:0] S_EVT  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       acc;

    assign o_ready = (r_state == S_HDR) || (r_state == S_CMD) || (r_state == S_DATA);
    assign acc     = i_valid && o_ready && !i_sts.rt;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_HDR: begin
                if (acc) begin
                    o_cmd.hdr_step = 1'b1;
                    if (i_sts.hdr_done) begin
                        n_state = S_CMD;
                    end
                end
            end
            S_CMD: begin
                if (acc) begin
                    if (!i_sts.st) begin
                        o_cmd.cmd_store = 1'b1;
                        if (i_sts.cmd_last) begin
                            n_state = S_DATA;
                        end
                    end else begin
                        o_cmd.to_hdr = 1'b1;
                        n_state      = S_HDR;
                    end
                end
            end
            S_DATA: begin
                if (acc) begin
                    if (!i_sts.st) begin
                        o_cmd.data_nib = 1'b1;
                    end else if (i_sts.eox) begin
                        o_cmd.end_msg = 1'b1;
                        n_state       = i_sts.page_ok ? S_RD : S_EVT;
                    end
                end
            end
            S_EVT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_evt = 1'b1;
                    n_state        = S_HDR;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WR;
            end
            S_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_word = 1'b1;
                    n_state         = i_sts.last_word ? S_HDR : S_RD;
                end
            end
            default: begin
                n_state = S_HDR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HDR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/slp_chk.sv =====
module slp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_rx_byte,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_event_kind,
    input logic [15:0] o_page_address,
    input logic [5:0]  o_word_offset,
    input logic [15:0] o_data_word,
    input logic        o_last
);

    import slp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_event_kind)
            && $stable(o_page_address) && $stable(o_word_offset)
            && $stable(o_data_word) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_evt_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind != EV_PAGE) |-> o_last)
        else $error("event beat without last");

    a_evt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind != EV_PAGE) |-> (o_word_offset == 6'd0)
            && (o_data_word == 16'd0))
        else $error("event beat carries word data");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == EV_PAGE) && !o_last |-> !o_ready)
        else $error("input taken in the middle of a page run");

endmodule

bind sysex_page_loader_parser slp_chk u_chk (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import slp_pkg::*;

    localparam int PAGE          = PAGE_BYTES_DEF;
    localparam int PAGE_WORDS    = (PAGE + 1) / 2;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 20;

    localparam logic [7:0] STATUS_MIN = 8'h80;
    localparam logic [7:0] RT_MIN     = 8'hF1;
    localparam logic [7:0] RT_MAX     = 8'hFF;

    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_CMD  = 2'd1,
        PH_DATA = 2'd2
    } t_parse_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [5:0]  offset;
        logic [15:0] word;
        logic        last;
    } t_slp_event;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_event_kind;
    logic [15:0] o_page_address;
    logic [5:0]  o_word_offset;
    logic [15:0] o_data_word;
    logic        o_last;

    logic [7:0] hdr_seq [6] = '{SYX_START, 8'h00, 8'h20, 8'h77, 8'h00, 8'h03};

    // parser shadow state
    t_parse_phase phase;
    logic [8:0]   nib_count;
    logic [7:0]   fill_idx;
    logic [7:0]   page_sum;
    logic [6:0]   cmd_bytes [2];
    logic [15:0]  load_addr;
    logic [7:0]   page_buf [0:PAGE];

    t_slp_event expected_events [$];
    t_slp_event want;
    int mismatches   = 0;
    int idle_cycles  = 0;
    int ready_left   = 0;
    bit no_idle      = 1'b0;
    bit rt_noise     = 1'b0;
    bit stat_noise   = 1'b0;

    sysex_page_loader_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_kind   (o_event_kind),
        .o_page_address (o_page_address),
        .o_word_offset  (o_word_offset),
        .o_data_word    (o_data_word),
        .o_last         (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic push_event(input logic [1:0] kind, input logic [5:0] offset,
                              input logic [15:0] word, input logic last);
        t_slp_event ev;
        ev.kind   = kind;
        ev.addr   = load_addr;
        ev.offset = offset;
        ev.word   = word;
        ev.last   = last;
        expected_events.push_back(ev);
    endtask

    task automatic track_byte(input logic [7:0] b);
        int i;
        if (b > SYX_START && b != SYX_END) return;
        case (phase)
            PH_CMD: begin
                if (b < STATUS_MIN) begin
                    cmd_bytes[nib_count[0]] = b[6:0];
                    nib_count = nib_count + 9'd1;
                    if (nib_count >= 9'd2) begin
                        nib_count = '0;
                        fill_idx  = '0;
                        page_sum  = '0;
                        phase     = PH_DATA;
                    end
                end else begin
                    phase     = PH_HDR;
                    nib_count = '0;
                end
            end
            PH_DATA: begin
                if (b < STATUS_MIN) begin
                    if (nib_count[0]) begin
                        if (fill_idx < PAGE + 1) begin
                            page_buf[fill_idx] = page_buf[fill_idx] | {4'h0, b[3:0]};
                            if (fill_idx < PAGE)
                                page_sum = page_sum + page_buf[fill_idx];
                        end
                        if (fill_idx < PAGE + 2)
                            fill_idx = fill_idx + 8'd1;
                    end else if (fill_idx < PAGE + 1) begin
                        page_buf[fill_idx] = {b[3:0], 4'h0};
                    end
                    nib_count = (nib_count == 9'd511) ? 9'd510 : nib_count + 9'd1;
                end else if (b == SYX_END) begin
                    if (cmd_bytes[0] == CMD_RESET && cmd_bytes[1] == CMD_ARG &&
                        nib_count == 0) begin
                        push_event(EV_RESET, 6'd0, 16'h0000, 1'b1);
                    end else if (fill_idx == PAGE + 1 && cmd_bytes[0] == CMD_PAGE &&
                                 cmd_bytes[1] == CMD_ARG && page_buf[PAGE] == page_sum) begin
                        for (i = 0; i < PAGE_WORDS; i++)
                            push_event(EV_PAGE, 6'(i),
                                       {page_buf[8'(2 * i + 1)], page_buf[8'(2 * i)]},
                                       i == PAGE_WORDS - 1);
                        load_addr = load_addr + 16'(PAGE);
                    end else begin
                        push_event(EV_ERROR, 6'd0, 16'h0000, 1'b1);
                    end
                    phase     = PH_HDR;
                    nib_count = '0;
                end
            end
            default: begin
                phase = PH_HDR;
                if (nib_count >= HDR_LEN) nib_count = '0;
                if (b == hdr_seq[nib_count[2:0]]) begin
                    nib_count = nib_count + 9'd1;
                    if (nib_count == HDR_LEN) begin
                        nib_count = '0;
                        phase     = PH_CMD;
                    end
                end else begin
                    nib_count = '0;
                end
            end
        endcase
    endtask

    // one input beat; valid stays high across back-to-back beats
    task automatic drive_beat(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        track_byte(b);
    endtask

    task automatic send_byte(input logic [7:0] b);
        logic [7:0] rt;
        if (rt_noise && $urandom_range(0, 99) < 5) begin
            do rt = 8'($urandom_range(RT_MIN, RT_MAX)); while (rt == SYX_END);
            drive_beat(rt);
        end
        drive_beat(b);
    endtask

    task automatic send_header();
        int k;
        for (k = 0; k < HDR_LEN; k++) send_byte(hdr_seq[3'(k)]);
    endtask

    task automatic send_data_byte(input logic [7:0] d);
        logic [2:0] hi;
        logic [2:0] lo;
        hi = 3'($urandom_range(0, 7));
        lo = 3'($urandom_range(0, 7));
        if (stat_noise && $urandom_range(0, 99) < 3)
            send_byte(8'($urandom_range(STATUS_MIN, SYX_START)));
        send_byte({1'b0, hi, d[7:4]});
        send_byte({1'b0, lo, d[3:0]});
    endtask

    task automatic send_cmd_msg(input logic [6:0] c0, input logic [6:0] c1, input int nnib);
        int k;
        send_header();
        send_byte({1'b0, c0});
        send_byte({1'b0, c1});
        for (k = 0; k < nnib; k++) send_byte(8'($urandom_range(0, 127)));
        send_byte(SYX_END);
    endtask

    // fill_mode: 0 random, 1 all zeros, 2 all ones
    task automatic send_page_msg(input int n_data, input int extra, input bit bad_sum,
                                 input bit half, input int fill_mode);
        logic [7:0] d;
        logic [7:0] sum;
        int k;
        sum = '0;
        send_header();
        send_byte({1'b0, CMD_PAGE});
        send_byte({1'b0, CMD_ARG});
        for (k = 0; k < n_data; k++) begin
            d = (fill_mode == 1) ? 8'h00 : (fill_mode == 2) ? 8'hFF : 8'($urandom);
            if (k < PAGE) sum = sum + d;
            send_data_byte(d);
        end
        send_data_byte(bad_sum ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum);
        for (k = 0; k < extra; k++) send_data_byte(8'($urandom));
        if (half) send_byte(8'($urandom_range(0, 127)));
        send_byte(SYX_END);
    endtask

    task automatic test_header_match();
        no_idle = 1'b1;
        // failed byte is not retried as a fresh start byte
        send_byte(SYX_START);
        send_byte(SYX_START);
        send_byte(8'h00); send_byte(8'h20); send_byte(8'h77);
        send_byte(8'h00); send_byte(8'h03);
        send_byte({1'b0, CMD_RESET}); send_byte({1'b0, CMD_ARG});
        send_byte(SYX_END);
        send_byte(SYX_START); send_byte(8'h00); send_byte(SYX_END);
        // realtime bytes inside the header
        send_byte(SYX_START); send_byte(8'h00); send_byte(8'h20);
        send_byte(8'hF8); send_byte(RT_MAX); send_byte(8'h77);
        send_byte(8'h00); send_byte(RT_MIN); send_byte(8'h03);
        send_byte({1'b0, CMD_RESET}); send_byte({1'b0, CMD_ARG});
        send_byte(8'hFE); send_byte(SYX_END);
        no_idle = 1'b0;
    endtask

    task automatic test_commands();
        rt_noise = 1'b1;
        send_cmd_msg(CMD_RESET, CMD_ARG, 0);
        send_cmd_msg(CMD_RESET, CMD_ARG, 1);
        send_cmd_msg(CMD_RESET, 7'h01, 0);
        send_cmd_msg(CMD_PAGE, CMD_ARG, 0);
        // status byte in command phase aborts
        send_header(); send_byte(STATUS_MIN);
        // status bytes in data phase are dropped
        send_header(); send_byte({1'b0, CMD_RESET}); send_byte({1'b0, CMD_ARG});
        send_byte(STATUS_MIN); send_byte(SYX_START); send_byte(8'hEF);
        send_byte(SYX_END);
        rt_noise = 1'b0;
    endtask

    task automatic test_page_load();
        stat_noise = 1'b1;
        send_page_msg(PAGE, 0, 1'b0, 1'b0, 0);
        stat_noise = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (no_idle) begin
            i_ready <= 1'b1;
            ready_left = 0;
        end else if (ready_left > 0) begin
            ready_left = ready_left - 1;
        end else if ($urandom_range(0, 99) < 50) begin
            i_ready <= 1'b1;
            ready_left = $urandom_range(0, 12);
        end else begin
            i_ready <= 1'b0;
            ready_left = idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind %0d addr %h off %0d word %h last %b",
                             o_event_kind, o_page_address, o_word_offset, o_data_word, o_last);
            end else begin
                want = expected_events.pop_front();
                if (o_event_kind !== want.kind || o_page_address !== want.addr ||
                    o_word_offset !== want.offset || o_data_word !== want.word ||
                    o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind %0d addr %h off %0d word %h last %b",
                                 want.kind, want.addr, want.offset, want.word, want.last,
                                 ", got kind %0d addr %h off %0d word %h last %b",
                                 o_event_kind, o_page_address, o_word_offset, o_data_word,
                                 o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        phase        = PH_HDR;
        nib_count    = '0;
        fill_idx     = '0;
        page_sum     = '0;
        cmd_bytes[0] = '0;
        cmd_bytes[1] = '0;
        load_addr    = '0;
        for (int k = 0; k <= PAGE; k++) page_buf[8'(k)] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_match();
        test_commands();
        test_page_load();
        i_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/slp_pkg.sv
src/slp_ram.sv
src/slp_dp.sv
src/slp_ctrl.sv
src/sysex_page_loader_parser.sv
src/slp_chk.sv
test/testbench.sv
